// File: src/u8sd_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 stream decoder.
`default_nettype none
package u8sd_pkg;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [7:0]  LEAD2_MIN      = 8'hC2;
  localparam logic [7:0]  LEAD4_MAX      = 8'hF4;
  localparam logic [20:0] MIN_CP_2       = 21'h000080;
  localparam logic [20:0] MIN_CP_3       = 21'h000800;
  localparam logic [20:0] MIN_CP_4       = 21'h010000;
  localparam logic [20:0] MAX_CP_2       = 21'h0007FF;
  localparam logic [20:0] MAX_CP_3       = 21'h00FFFF;
  localparam logic [20:0] MAX_CP_4       = 21'h10FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_error;
    logic [2:0]  byte_count;
    logic        last_of_run;
  } out_item_t;

  // Work for the back end: some one-byte errors, then optionally one final result.
  typedef struct packed {
    logic [1:0]  err_cnt;
    logic        has_final;
    logic [20:0] final_cp;
    logic        final_err;
    logic [2:0]  final_cnt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // 0 = invalid lead, 1 = ASCII, 2..4 = multi-byte lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b >= LEAD2_MIN && b <= 8'hDF) begin
      len = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      len = 3'd3;
    end else if (b >= 8'hF0 && b <= LEAD4_MAX) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [20:0] min_code(input logic [2:0] len);
    logic [20:0] v;
    unique case (len)
      3'd2:    v = MIN_CP_2;
      3'd3:    v = MIN_CP_3;
      3'd4:    v = MIN_CP_4;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

  function automatic logic [20:0] max_code(input logic [2:0] len);
    logic [20:0] v;
    unique case (len)
      3'd2:    v = MAX_CP_2;
      3'd3:    v = MAX_CP_3;
      3'd4:    v = MAX_CP_4;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/utf8_stream_decoder_core.sv
// Streaming UTF-8 decoder top level: front end, job queue, back end.
//
// Decodes a UTF-8 byte stream, one byte per input transfer, into code points
// with their byte counts; malformed input gives U+FFFD with is_error set.
// A byte is taken every cycle as long as the job queue has room. Each byte
// that produces results posts one job; the back end drives one result per
// cycle through its output register while out_ready is high, so a byte
// that yields k results (k is at most 4) takes k output transfers. The
// QUEUE_DEPTH-entry job queue lets input keep flowing while those extra
// results drain or while the output side stalls.
`default_nettype none
module utf8_stream_decoder_core
  import u8sd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  q_status_t q_status;
  logic      job_push;
  job_t      push_job;
  logic      job_pop;
  job_t      head_job;

  u8sd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .job_push (job_push),
    .job      (push_job)
  );

  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  u8sd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head_job  (head_job),
    .job_pop   (job_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: src/u8sd_front.sv
// Front end: takes bytes, tracks the pending sequence and posts jobs.
`default_nettype none
module u8sd_front
  import u8sd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire q_status_t q_status,
  output logic           job_push,
  output job_t           job
);

  logic [2:0]  exp_len_r, exp_len_nxt;
  logic [2:0]  coll_r, coll_nxt;
  logic [20:0] part_r, part_nxt;

  logic [7:0]  b;
  logic        last;
  logic [2:0]  lead_len;
  logic        pending;
  logic        cont;
  logic        lead_take;
  logic [2:0]  new_coll;
  logic [20:0] new_part;
  logic        accept;

  assign b        = in_data.data_byte;
  assign last     = in_data.end_of_stream;
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign lead_len = lead_length(b);
  assign cont     = (b[7:6] == 2'b10);
  assign pending  = (exp_len_r >= 3'd2) && (exp_len_r <= 3'd4) &&
                    (coll_r >= 3'd1) && (coll_r < exp_len_r);
  assign new_coll = coll_r + 3'd1;
  assign new_part = {part_r[14:0], b[5:0]};

  always_comb begin
    exp_len_nxt = exp_len_r;
    coll_nxt    = coll_r;
    part_nxt    = part_r;
    job         = '0;
    lead_take   = 1'b1;

    if (pending && cont) begin
      lead_take = 1'b0;
      if (new_coll == exp_len_r) begin
        exp_len_nxt   = 3'd0;
        coll_nxt      = 3'd0;
        part_nxt      = '0;
        job.has_final = 1'b1;
        job.final_cnt = exp_len_r;
        if (new_part < min_code(exp_len_r) || new_part > max_code(exp_len_r)) begin
          job.final_cp  = REPLACEMENT_CP;
          job.final_err = 1'b1;
        end else begin
          job.final_cp  = new_part;
        end
      end else if (last) begin
        // stream ends mid-sequence: every byte taken becomes an error
        job.err_cnt = new_coll[1:0];
        exp_len_nxt = 3'd0;
        coll_nxt    = 3'd0;
        part_nxt    = '0;
      end else begin
        coll_nxt = new_coll;
        part_nxt = new_part;
      end
    end else begin
      if (pending) begin
        job.err_cnt = coll_r[1:0];
      end
      exp_len_nxt = 3'd0;
      coll_nxt    = 3'd0;
      part_nxt    = '0;
    end

    if (lead_take) begin
      unique case (lead_len)
        3'd0: begin
          job.has_final = 1'b1;
          job.final_cp  = REPLACEMENT_CP;
          job.final_err = 1'b1;
          job.final_cnt = 3'd1;
        end
        3'd1: begin
          job.has_final = 1'b1;
          job.final_cp  = {13'd0, b};
          job.final_cnt = 3'd1;
        end
        default: begin
          if (last) begin
            job.has_final = 1'b1;
            job.final_cp  = REPLACEMENT_CP;
            job.final_err = 1'b1;
            job.final_cnt = 3'd1;
          end else begin
            exp_len_nxt = lead_len;
            coll_nxt    = 3'd1;
            unique case (lead_len)
              3'd2:    part_nxt = {16'd0, b[4:0]};
              3'd3:    part_nxt = {17'd0, b[3:0]};
              default: part_nxt = {18'd0, b[2:0]};
            endcase
          end
        end
      endcase
    end
  end

  assign job_push = accept && (job.has_final || (job.err_cnt != 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= 3'd0;
      coll_r    <= 3'd0;
      part_r    <= '0;
    end else if (accept) begin
      exp_len_r <= exp_len_nxt;
      coll_r    <= coll_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/u8sd_queue.sv
// Small job queue between the front and back ends.
`default_nettype none
module u8sd_queue
  import u8sd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output q_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count_r == CW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// File: src/u8sd_back.sv
// Back end: expands each job into result transfers through an output register.
`default_nettype none
module u8sd_back
  import u8sd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_status,
  input  wire job_t      head_job,
  output logic           job_pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;
  out_item_t  res;
  logic       load;
  logic       err_slot;

  assign load     = !q_status.empty && (!out_valid_r || out_ready);
  assign err_slot = (idx_r < head_job.err_cnt);

  always_comb begin
    if (err_slot) begin
      res.code_point  = REPLACEMENT_CP;
      res.is_error    = 1'b1;
      res.byte_count  = 3'd1;
      res.last_of_run = (idx_r == head_job.err_cnt - 2'd1) && !head_job.has_final;
    end else begin
      res.code_point  = head_job.final_cp;
      res.is_error    = head_job.final_err;
      res.byte_count  = head_job.final_cnt;
      res.last_of_run = 1'b1;
    end
  end

  assign job_pop = load && res.last_of_run;

  always_comb begin
    idx_nxt = idx_r;
    if (job_pop) begin
      idx_nxt = 2'd0;
    end else if (load) begin
      idx_nxt = idx_r + 2'd1;
    end
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: tb/utf8_stream_decoder_core_test.sv
// Self-checking testbench for the UTF-8 stream decoder core, with a built-in decode predictor.
`timescale 1ns / 1ps
module utf8_stream_decoder_core_test;
  import u8sd_pkg::*;

  localparam int RANDOM_BYTES = 480;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  utf8_stream_decoder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  in_item_t  byte_stream_q[$];
  out_item_t expected_chars_q[$];

  // predictor state: pending sequence
  logic [2:0]  seq_len;
  logic [2:0]  seq_got;
  logic [20:0] seq_code;
  out_item_t   step_res[4];
  int          step_n;

  int   accepted_bytes;
  int   err_count;
  int   quiet_cycles;
  logic in_took;
  int   hold_left;
  logic hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // stimulus construction
  function automatic void add_byte(logic [7:0] b, logic eos);
    in_item_t it;
    it.data_byte     = b;
    it.end_of_stream = eos;
    byte_stream_q.push_back(it);
  endfunction

  // pushes the first 'keep' bytes of the len-byte encoding of cp
  function automatic void add_char(logic [20:0] cp, int len, int keep, int eos_pct);
    logic [7:0] b[4];
    b[1] = {2'b10, cp[5:0]};
    b[2] = 8'h00;
    b[3] = 8'h00;
    case (len)
      1: b[0] = {1'b0, cp[6:0]};
      2: b[0] = {3'b110, cp[10:6]};
      3: begin
        b[0] = {4'b1110, cp[15:12]};
        b[1] = {2'b10, cp[11:6]};
        b[2] = {2'b10, cp[5:0]};
      end
      default: begin
        b[0] = {5'b11110, cp[20:18]};
        b[1] = {2'b10, cp[17:12]};
        b[2] = {2'b10, cp[11:6]};
        b[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++)
      add_byte(b[i], $urandom_range(99) < eos_pct);
  endfunction

  function automatic logic [20:0] legal_code(int len);
    case (len)
      1:       return 21'($urandom_range(8'h7F, 0));
      2:       return 21'($urandom_range(MAX_CP_2, MIN_CP_2));
      3:       return 21'($urandom_range(MAX_CP_3, MIN_CP_3));
      default: return 21'($urandom_range(MAX_CP_4, MIN_CP_4));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // decode predictor
  function automatic logic [2:0] seq_size_of(logic [7:0] b);
    if (!b[7])                           return 3'd1;
    if (b >= LEAD2_MIN && b <= 8'hDF)    return 3'd2;
    if (b >= 8'hE0 && b <= 8'hEF)        return 3'd3;
    if (b >= 8'hF0 && b <= LEAD4_MAX)    return 3'd4;
    return 3'd0;
  endfunction

  function automatic void note_char(logic [20:0] cp, logic err, logic [2:0] cnt);
    step_res[step_n] = {cp, err, cnt, 1'b0};
    step_n++;
  endfunction

  function automatic void drop_sequence();
    seq_len  = 3'd0;
    seq_got  = 3'd0;
    seq_code = 21'd0;
  endfunction

  // every byte taken so far turns into its own one-byte error
  function automatic void flush_taken();
    for (int i = 0; i < seq_got; i++)
      note_char(REPLACEMENT_CP, 1'b1, 3'd1);
    drop_sequence();
  endfunction

  function automatic void start_char(logic [7:0] b, logic eos);
    logic [2:0] len;
    len = seq_size_of(b);
    if (len == 3'd0 || (len > 3'd1 && eos)) begin
      note_char(REPLACEMENT_CP, 1'b1, 3'd1);
    end else if (len == 3'd1) begin
      note_char({13'd0, b}, 1'b0, 3'd1);
    end else begin
      seq_len  = len;
      seq_got  = 3'd1;
      seq_code = {13'd0, b} & ((21'd1 << (7 - len)) - 21'd1);
    end
  endfunction

  function automatic void decode_byte(in_item_t it);
    logic [7:0]  b;
    logic        eos;
    logic [2:0]  len;
    logic [20:0] cp;
    logic        bad;
    b      = it.data_byte;
    eos    = it.end_of_stream;
    step_n = 0;
    if (seq_len == 3'd0) begin
      start_char(b, eos);
    end else if (b[7:6] != 2'b10) begin
      flush_taken();
      start_char(b, eos);
    end else begin
      seq_code = {seq_code[14:0], b[5:0]};
      seq_got  = seq_got + 3'd1;
      if (seq_got == seq_len) begin
        len = seq_len;
        cp  = seq_code;
        drop_sequence();
        case (len)
          3'd2:    bad = cp < MIN_CP_2 || cp > MAX_CP_2;
          3'd3:    bad = cp < MIN_CP_3 || cp > MAX_CP_3;
          default: bad = cp < MIN_CP_4 || cp > MAX_CP_4;
        endcase
        if (bad) note_char(REPLACEMENT_CP, 1'b1, len);
        else     note_char(cp, 1'b0, len);
      end else if (eos) begin
        flush_taken();
      end
    end
    for (int i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_res[i].last_of_run = 1'b1;
      expected_chars_q.push_back(step_res[i]);
    end
  endfunction

  // idle percentages move through three phases as bytes are accepted
  function automatic int tx_idle_pct();
    if (accepted_bytes < 170) return 27;
    if (accepted_bytes < 340) return 56;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (accepted_bytes < 170) return 56;
    if (accepted_bytes < 340) return 27;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || in_took) begin
      if (byte_stream_q.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
        in_valid <= 1'b1;
        in_data  <= byte_stream_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side ready, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_bytes >= 150) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= $urandom_range(99) >= rx_idle_pct();
    end
  end

  // monitor: check results, feed the predictor, watch for a hang
  always @(posedge clk) begin
    out_item_t exp_c;
    if (!rst_n) begin
      in_took      <= 1'b0;
      quiet_cycles <= 0;
      drop_sequence();
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_chars_q.size() == 0) begin
          $error("unexpected result transfer: code_point %h", out_data.code_point);
          err_count++;
        end else begin
          exp_c = expected_chars_q.pop_front();
          if (out_data.code_point !== exp_c.code_point) begin
            $error("code_point: expected %h, got %h", exp_c.code_point, out_data.code_point);
            err_count++;
          end
          if (out_data.is_error !== exp_c.is_error) begin
            $error("is_error: expected %b, got %b", exp_c.is_error, out_data.is_error);
            err_count++;
          end
          if (out_data.byte_count !== exp_c.byte_count) begin
            $error("byte_count: expected %0d, got %0d", exp_c.byte_count, out_data.byte_count);
            err_count++;
          end
          if (out_data.last_of_run !== exp_c.last_of_run) begin
            $error("last_of_run: expected %b, got %b", exp_c.last_of_run,
                   out_data.last_of_run);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        accepted_bytes++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("utf8_stream_decoder_core_test: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  initial begin
    int         pick;
    int         len;
    logic [7:0] b;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    accepted_bytes = 0;
    err_count      = 0;

    // directed: extremes, bad leads, range limits, breaks, early end of stream
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);                      // invalid lead
    add_byte(8'h80, 1'b0);                      // stray continuation
    add_byte(8'hC1, 1'b0);                      // overlong-only lead
    add_char(MIN_CP_2, 2, 2, 0);
    add_char(MAX_CP_2, 2, 2, 0);
    add_char(21'h0007FF, 3, 3, 0);              // overlong three-byte form
    add_char(21'h110000, 4, 4, 0);              // above the top of the code space
    add_char(MIN_CP_4, 4, 3, 0);
    add_byte(8'h41, 1'b0);                      // breaks the three-byte prefix
    add_byte(8'hF4, 1'b0);
    add_byte(8'h8F, 1'b0);
    add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b1);                      // completes on the final byte
    add_byte(8'hE2, 1'b1);                      // lead on the final byte
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b1);                      // stream ends mid-sequence

    while (byte_stream_q.size() < RANDOM_BYTES + 25) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        len = $urandom_range(4, 1);
        add_char(legal_code(len), len, len, 4);
      end else if (pick < 62) begin
        len = $urandom_range(4, 2);
        if (len == 4 && $urandom_range(1)) add_char(21'($urandom_range(21'h1FFFFF, 21'h110000)),
                                                   4, 4, 4);
        else add_char(legal_code(len - 1), len, len, 4);
      end else if (pick < 80) begin
        len = $urandom_range(4, 2);
        add_char(legal_code(len), len, $urandom_range(len - 1, 1), 4);
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        add_byte(b, $urandom_range(99) < 8);
      end else begin
        add_byte(8'($urandom_range(255)), $urandom_range(99) < 8);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (byte_stream_q.size() > 0 || in_valid || expected_chars_q.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    if (err_count == 0) begin
      $display("utf8_stream_decoder_core_test: clean");
    end else begin
      $display("utf8_stream_decoder_core_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/u8sd_pkg.sv
src/u8sd_front.sv
src/u8sd_queue.sv
src/u8sd_back.sv
src/utf8_stream_decoder_core.sv
tb/utf8_stream_decoder_core_test.sv
